>>> rtl/spsg_pkg.sv
// Package for the strided pattern splitter: widths, register indexes,
// queue word and state types. No dependencies.
`default_nettype none
package spsg_pkg;
   localparam int AddrW = 32;
   localparam int SizeW = 25;
   localparam int BytesW = 24;
   localparam int RowsW = 16;
   localparam int QDepth = 2;

   typedef enum logic [1:0] {
      CSR_START_OFFSET = 2'd0,
      CSR_ROW_BYTES    = 2'd1,
      CSR_ROW_STRIDE   = 2'd2,
      CSR_ROW_TOTAL    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [AddrW-1:0] seg_addr;
      logic [SizeW-1:0] seg_size;
      logic             first_segment;
      logic             last_segment;
   } seg_word_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_PLAN, ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic             result_kind;
      logic [AddrW-1:0] desc_addr;
      logic [BytesW-1:0] desc_row_bytes;
      logic [RowsW-1:0] desc_rows;
      logic [RowsW-1:0] desc_index;
      logic             run_last;
      logic             pattern_done;
   } rsp_word_type;
endpackage
`default_nettype wire

>>> rtl/spsg_front.sv
// Front end: accepts segment words into a short queue for the back end.
// Depends on spsg_pkg.
`default_nettype none
module spsg_front import spsg_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire seg_word_type req_word,
   output logic              q_valid,
   output seg_word_type      q_word,
   input  wire logic         q_pop
);
   seg_word_type mem_ff [QDepth];
   logic wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   assign req_stall = (cnt_ff == 2'(QDepth));
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_word = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? ~wr_ff : wr_ff;
      rd_in = q_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= req_word;
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QDepth)) else $error("queue count overflow");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'(QDepth)) && !q_pop |=> req_stall) else $error("full queue not held");
endmodule
`default_nettype wire

>>> rtl/spsg_divider.sv
// Restoring divider, one quotient bit a cycle, 25-bit dividend by 24-bit divisor.
// Depends on spsg_pkg.
`default_nettype none
module spsg_divider import spsg_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SizeW-1:0]  dividend,
   input  wire logic [BytesW-1:0] divisor,
   output logic                   done,
   output logic [SizeW-1:0]       quot,
   output logic [BytesW:0]        rem
);
   logic [SizeW-1:0] q_ff, q_in;
   logic [BytesW:0] r_ff, r_in;
   logic [BytesW-1:0] d_ff;
   logic [4:0] n_ff, n_in;
   logic busy_ff, busy_in;
   logic [BytesW+1:0] trial;

   always_comb begin
      trial = {r_ff, q_ff[SizeW-1]};
      q_in = {q_ff[SizeW-2:0], 1'b0};
      r_in = trial[BytesW:0];
      if (trial >= {2'b00, d_ff}) begin
         r_in = (BytesW+1)'(trial - {2'b00, d_ff});
         q_in[0] = 1'b1;
      end
      n_in = n_ff - 5'd1;
      busy_in = busy_ff && (n_ff != 5'd1);
   end

   assign done = busy_ff && (n_ff == 5'd1);
   assign quot = q_in;
   assign rem = r_in;

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= dividend; r_ff <= '0; d_ff <= divisor; n_ff <= 5'(SizeW);
      end else if (busy_ff) begin
         q_ff <= q_in; r_ff <= r_in; n_ff <= n_in;
      end
      if (reset) busy_ff <= 1'b0;
      else if (start) busy_ff <= 1'b1;
      else busy_ff <= busy_in;
   end
endmodule
`default_nettype wire

>>> rtl/spsg_back.sv
// Back end: holds the pattern state, divides the free span by the stride and
// emits up to three result words per segment. Depends on spsg_pkg, spsg_divider.
`default_nettype none
module spsg_back import spsg_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [AddrW-1:0]  start_offset,
   input  wire logic [BytesW-1:0] row_bytes,
   input  wire logic [BytesW-1:0] row_stride,
   input  wire logic [RowsW-1:0]  row_total,
   input  wire logic              q_valid,
   input  wire seg_word_type      q_word,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_word_type           rsp_word
);
   back_state_type st_ff, st_in;
   seg_word_type seg_ff;
   logic [AddrW-1:0] pos_ff, pos_in;
   logic [RowsW-1:0] left_ff, left_in;
   logic pend_ff, pend_in, fin_ff, fin_in;
   logic [BytesW-1:0] rlen_ff, rlen_in;
   logic [RowsW-1:0] cnt_ff;
   logic [SizeW-1:0] whole_ff;
   logic [BytesW:0] frac_ff;
   logic [BytesW-1:0] st;
   rsp_word_type slot_ff [3], slot_in [3];
   logic [2:0] sv_ff, sv_in;
   logic [1:0] si_ff;
   logic div_start, div_done;
   logic [SizeW-1:0] div_q;
   logic [BytesW:0] div_r;
   logic [AddrW-1:0] s_pos;
   logic [RowsW-1:0] s_left, s_cnt;
   logic s_pend, s_fin, fire, skip, done_c;
   logic [SizeW-1:0] avail;
   logic [AddrW-1:0] base;
   logic [1:0] nres;
   logic wait_div_ff;

   assign st = (row_stride == '0) ? BytesW'(1) : row_stride;
   assign s_pos  = seg_ff.first_segment ? start_offset : pos_ff;
   assign s_left = seg_ff.first_segment ? row_total : left_ff;
   assign s_pend = seg_ff.first_segment ? 1'b0 : pend_ff;
   assign s_fin  = seg_ff.first_segment ? 1'b0 : fin_ff;
   assign s_cnt  = seg_ff.first_segment ? '0 : cnt_ff;
   assign skip = (s_pos >= AddrW'(seg_ff.seg_size));
   assign avail = seg_ff.seg_size - SizeW'(s_pos);
   assign base = seg_ff.seg_addr + s_pos;

   spsg_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(avail),
      .divisor(st), .done(div_done), .quot(div_q), .rem(div_r)
   );

   assign q_pop = (st_ff == ST_IDLE) && q_valid;
   assign div_start = (st_ff == ST_DIV) && !wait_div_ff && !s_fin && (s_left != '0) && !skip;
   assign rsp_valid = (st_ff == ST_EMIT) && sv_ff[si_ff];
   assign rsp_word = slot_ff[si_ff];
   assign fire = rsp_valid && !rsp_stall;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (q_valid) st_in = ST_DIV;
         ST_DIV:  if (!div_start) st_in = ST_PLAN;
                  else st_in = ST_DIV;
         ST_PLAN: st_in = ST_EMIT;
         ST_EMIT: if (sv_ff == '0 || (fire && si_ff == 2'd2) ||
                      (fire && sv_ff[si_ff+2'd1] == 1'b0 && si_ff != 2'd2))
                     st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      logic [RowsW-1:0] c;
      logic [SizeW-1:0] w;
      logic [BytesW:0] f;
      c = s_cnt;
      w = whole_ff; f = frac_ff;
      pos_in = s_pos; left_in = s_left; pend_in = s_pend; rlen_in = pend_ff ? rlen_ff : '0;
      if (seg_ff.first_segment) rlen_in = '0;
      fin_in = s_fin;
      for (int i = 0; i < 3; i++) slot_in[i] = '0;
      sv_in = '0;
      nres = 2'd0;
      if (!s_fin) begin
         if (s_pend) begin
            slot_in[0] = '{1'b0, seg_ff.seg_addr, rlen_in, RowsW'(1), c, 1'b0, 1'b0};
            sv_in[0] = 1'b1; c = c + 1'b1; nres = 2'd1; pend_in = 1'b0;
         end
         if (s_left != '0) begin
            if (skip) pos_in = s_pos - AddrW'(seg_ff.seg_size);
            else if (w >= SizeW'(s_left)) begin
               slot_in[nres] = '{1'b0, base, row_bytes, s_left, c, 1'b0, 1'b0};
               sv_in[nres] = 1'b1; c = c + 1'b1; nres = nres + 2'd1; left_in = '0;
            end else if (f == '0) begin
               slot_in[nres] = '{1'b0, base, row_bytes, RowsW'(w), c, 1'b0, 1'b0};
               sv_in[nres] = 1'b1; c = c + 1'b1; nres = nres + 2'd1;
               left_in = s_left - RowsW'(w); pos_in = '0;
            end else if (f < {1'b0, row_bytes}) begin
               if (w != '0) begin
                  slot_in[nres] = '{1'b0, base, row_bytes, RowsW'(w), c, 1'b0, 1'b0};
                  sv_in[nres] = 1'b1; c = c + 1'b1; nres = nres + 2'd1;
                  left_in = s_left - RowsW'(w);
               end
               if (!seg_ff.last_segment) begin
                  slot_in[nres] = '{1'b0,
                                    seg_ff.seg_addr + AddrW'(seg_ff.seg_size) - AddrW'(f),
                                    BytesW'(f), RowsW'(1), c, 1'b0, 1'b0};
                  sv_in[nres] = 1'b1; c = c + 1'b1; nres = nres + 2'd1;
                  pend_in = 1'b1; rlen_in = row_bytes - BytesW'(f);
                  left_in = left_in - 1'b1; pos_in = AddrW'(st) - AddrW'(f);
               end
            end else begin
               slot_in[nres] = '{1'b0, base, row_bytes, RowsW'(w + 1'b1), c, 1'b0, 1'b0};
               sv_in[nres] = 1'b1; c = c + 1'b1; nres = nres + 2'd1;
               left_in = s_left - RowsW'(w + 1'b1); pos_in = AddrW'(st) - AddrW'(f);
            end
         end
         done_c = (left_in == '0) && !pend_in;
         if (done_c) fin_in = 1'b1;
         else if (seg_ff.last_segment) begin
            slot_in[nres] = '{1'b1, '0, '0, left_in, c, 1'b0, 1'b0};
            sv_in[nres] = 1'b1; nres = nres + 2'd1; fin_in = 1'b1;
         end
         for (int i = 0; i < 3; i++) begin
            slot_in[i].pattern_done = done_c;
            slot_in[i].run_last = sv_in[i] && (i == 2 || !sv_in[(i+1)%3] || i == 2);
         end
      end else done_c = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (q_pop) seg_ff <= q_word;
      if (div_done) begin whole_ff <= div_q; frac_ff <= div_r; end
      if (st_ff == ST_PLAN) begin
         for (int i = 0; i < 3; i++) slot_ff[i] <= slot_in[i];
      end
      if (reset) begin
         st_ff <= ST_IDLE; left_ff <= '0; pend_ff <= 1'b0; fin_ff <= 1'b0;
         cnt_ff <= '0; sv_ff <= '0; si_ff <= '0; wait_div_ff <= 1'b0;
         pos_ff <= '0; rlen_ff <= '0;
      end else begin
         st_ff <= (st_ff == ST_DIV && div_start && !div_done) ? ST_DIV :
                  (st_ff == ST_DIV && wait_div_ff && !div_done) ? ST_DIV : st_in;
         wait_div_ff <= (st_ff == ST_DIV) && (div_start || wait_div_ff) && !div_done;
         if (st_ff == ST_PLAN) begin
            left_ff <= left_in; pend_ff <= pend_in; fin_ff <= fin_in;
            pos_ff <= pos_in; rlen_ff <= rlen_in;
            cnt_ff <= s_cnt + RowsW'(sv_in[0] && !slot_in[0].result_kind)
                    + RowsW'(sv_in[1] && !slot_in[1].result_kind)
                    + RowsW'(sv_in[2] && !slot_in[2].result_kind);
            sv_ff <= sv_in; si_ff <= '0;
         end else if (fire) si_ff <= si_ff + 2'd1;
         if (st_ff == ST_IDLE && q_valid) begin
            whole_ff <= '0; frac_ff <= '0;
         end
      end
   end

   a_emit_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (st_ff == ST_EMIT)) else $error("result outside emit");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (st_ff == ST_DIV)) else $error("pop did not start work");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(si_ff)) else $error("stalled word lost");
endmodule
`default_nettype wire

>>> rtl/strided_pattern_sg_descriptor_split.sv
// Top level: segment queue, pattern back end and configuration registers.
// Depends on spsg_pkg, spsg_front, spsg_back.
//  channel | direction | handshake
//  req_    | in        | req_valid / req_stall, one segment per word
//  rsp_    | out       | rsp_valid / rsp_stall, up to three words per segment
//  csr_    | in        | csr_write, no wait
// Without stalls a segment goes through pop, the serial divider, plan, then the
// emission of each result word; the divider is skipped when no division is needed.
// Reset is synchronous; the run is closed until a first segment arrives.
// Two segments queue while the back end works or rsp_stall is high.
`default_nettype none
module strided_pattern_sg_descriptor_split import spsg_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [AddrW-1:0]  req_seg_addr,
   input  wire logic [SizeW-1:0]  req_seg_size,
   input  wire logic              req_first_segment,
   input  wire logic              req_last_segment,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_result_kind,
   output logic [AddrW-1:0]       rsp_desc_addr,
   output logic [BytesW-1:0]      rsp_desc_row_bytes,
   output logic [RowsW-1:0]       rsp_desc_rows,
   output logic [RowsW-1:0]       rsp_desc_index,
   output logic                   rsp_run_last,
   output logic                   rsp_pattern_done
);
   logic [AddrW-1:0] so_ff;
   logic [BytesW-1:0] rb_ff, rs_ff;
   logic [RowsW-1:0] rt_ff;
   logic q_valid, q_pop;
   seg_word_type q_word, req_word;
   rsp_word_type rw;

   always_ff @(posedge clock) begin
      if (reset) begin
         so_ff <= '0; rb_ff <= BytesW'(1); rs_ff <= BytesW'(1); rt_ff <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_START_OFFSET: so_ff <= csr_data;
            CSR_ROW_BYTES:    rb_ff <= csr_data[BytesW-1:0];
            CSR_ROW_STRIDE:   rs_ff <= csr_data[BytesW-1:0];
            CSR_ROW_TOTAL:    rt_ff <= csr_data[RowsW-1:0];
            default: ;
         endcase
      end
   end

   assign req_word = '{req_seg_addr, req_seg_size, req_first_segment, req_last_segment};

   spsg_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_word(req_word), .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop)
   );

   spsg_back u_back (
      .clock(clock), .reset(reset), .start_offset(so_ff), .row_bytes(rb_ff),
      .row_stride(rs_ff), .row_total(rt_ff), .q_valid(q_valid), .q_word(q_word),
      .q_pop(q_pop), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rw)
   );

   assign rsp_result_kind = rw.result_kind;
   assign rsp_desc_addr = rw.desc_addr;
   assign rsp_desc_row_bytes = rw.desc_row_bytes;
   assign rsp_desc_rows = rw.desc_rows;
   assign rsp_desc_index = rw.desc_index;
   assign rsp_run_last = rw.run_last;
   assign rsp_pattern_done = rw.pattern_done;
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Testbench for strided_pattern_sg_descriptor_split: drives segments, writes
// the pattern registers between phases and checks every descriptor word.
// Depends on spsg_pkg and the RTL top level.
`default_nettype none
module testbench;
   import spsg_pkg::*;

   class desc_scoreboard;
      logic [31:0] start_offset;
      logic [23:0] row_bytes;
      logic [23:0] row_stride;
      logic [15:0] row_total;
      logic [31:0] seg_pos;
      logic [15:0] rows_left;
      bit          tail_owed;
      logic [23:0] tail_len;
      logic [15:0] desc_count;
      bit          closed;
      rsp_word_type expected_q[$];
      int          errors;
      int          words_checked;
      int          error_words;

      function new();
         start_offset = 0;
         row_bytes = 1;
         row_stride = 1;
         row_total = 0;
         seg_pos = 0;
         rows_left = 0;
         tail_owed = 0;
         tail_len = 0;
         desc_count = 0;
         closed = 0;
         errors = 0;
         words_checked = 0;
         error_words = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] val);
         case (idx)
            CSR_START_OFFSET: start_offset = val;
            CSR_ROW_BYTES:    row_bytes = val[23:0];
            CSR_ROW_STRIDE:   row_stride = val[23:0];
            CSR_ROW_TOTAL:    row_total = val[15:0];
            default: ;
         endcase
      endfunction

      function void push_desc(rsp_word_type w[$], ref rsp_word_type pend[$],
                              input bit kind, input logic [31:0] a,
                              input logic [23:0] b, input logic [15:0] r);
         rsp_word_type x;
         x = '0;
         x.result_kind = kind;
         x.desc_addr = a;
         x.desc_row_bytes = b;
         x.desc_rows = r;
         x.desc_index = desc_count;
         if (!kind) desc_count = desc_count + 16'd1;
         pend.push_back(x);
      endfunction

      function void note_segment(logic [31:0] addr, logic [24:0] size, bit first,
                                 bit last);
         rsp_word_type pend[$];
         rsp_word_type none[$];
         logic [31:0] avail, st, whole, frac, base;
         bit done;
         if (first) begin
            seg_pos = start_offset;
            rows_left = row_total;
            tail_owed = 0;
            tail_len = 0;
            desc_count = 0;
            closed = 0;
         end
         if (closed) return;
         if (tail_owed) begin
            push_desc(none, pend, 0, addr, tail_len, 16'd1);
            tail_owed = 0;
         end
         if (rows_left > 0) begin
            if (seg_pos >= {7'd0, size}) begin
               seg_pos = seg_pos - {7'd0, size};
            end else begin
               avail = {7'd0, size} - seg_pos;
               st = (row_stride == 0) ? 32'd1 : {8'd0, row_stride};
               whole = avail / st;
               frac = avail % st;
               base = addr + seg_pos;
               if (whole >= {16'd0, rows_left}) begin
                  push_desc(none, pend, 0, base, row_bytes, rows_left);
                  rows_left = 0;
               end else if (frac == 0) begin
                  push_desc(none, pend, 0, base, row_bytes, whole[15:0]);
                  rows_left = rows_left - whole[15:0];
                  seg_pos = 0;
               end else if (frac < {8'd0, row_bytes}) begin
                  if (whole != 0) begin
                     push_desc(none, pend, 0, base, row_bytes, whole[15:0]);
                     rows_left = rows_left - whole[15:0];
                  end
                  if (!last) begin
                     push_desc(none, pend, 0, base + whole * st, frac[23:0], 16'd1);
                     tail_owed = 1;
                     tail_len = row_bytes - frac[23:0];
                     rows_left = rows_left - 16'd1;
                     seg_pos = st - frac;
                  end
               end else begin
                  push_desc(none, pend, 0, base, row_bytes, whole[15:0] + 16'd1);
                  rows_left = rows_left - (whole[15:0] + 16'd1);
                  seg_pos = st - frac;
               end
            end
         end
         done = (rows_left == 0) && !tail_owed;
         if (done) begin
            closed = 1;
         end else if (last) begin
            push_desc(none, pend, 1, 32'd0, 24'd0, rows_left);
            error_words++;
            closed = 1;
         end
         foreach (pend[k]) begin
            pend[k].run_last = (k == pend.size() - 1);
            pend[k].pattern_done = done;
            expected_q.push_back(pend[k]);
         end
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type exp;
         words_checked++;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word %p", got);
            return;
         end
         exp = expected_q.pop_front();
         if (got !== exp) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", exp, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write;
   logic [1:0] csr_index;
   logic [31:0] csr_data;
   logic req_valid;
   logic req_stall;
   logic [31:0] req_seg_addr;
   logic [24:0] req_seg_size;
   logic req_first_segment;
   logic req_last_segment;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_result_kind;
   logic [31:0] rsp_desc_addr;
   logic [23:0] rsp_desc_row_bytes;
   logic [15:0] rsp_desc_rows;
   logic [15:0] rsp_desc_index;
   logic rsp_run_last;
   logic rsp_pattern_done;

   desc_scoreboard sb;
   bit hold_rsp;
   int idle_cycles;
   int seg_count;

   strided_pattern_sg_descriptor_split u_top (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_seg_addr(req_seg_addr), .req_seg_size(req_seg_size),
      .req_first_segment(req_first_segment), .req_last_segment(req_last_segment),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind), .rsp_desc_addr(rsp_desc_addr),
      .rsp_desc_row_bytes(rsp_desc_row_bytes), .rsp_desc_rows(rsp_desc_rows),
      .rsp_desc_index(rsp_desc_index), .rsp_run_last(rsp_run_last),
      .rsp_pattern_done(rsp_pattern_done)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      sb = new();
      reset = 1;
      csr_write = 0;
      csr_index = CSR_START_OFFSET;
      csr_data = 0;
      req_valid = 0;
      req_seg_addr = 0;
      req_seg_size = 0;
      req_first_segment = 0;
      req_last_segment = 0;
      rsp_stall = 0;
      hold_rsp = 0;
   end

   // receiver: own stall pattern, long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_rsp) begin
         rsp_stall <= 1;
      end else begin
         case ((seg_count / 40) % 3)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         w.result_kind = rsp_result_kind;
         w.desc_addr = rsp_desc_addr;
         w.desc_row_bytes = rsp_desc_row_bytes;
         w.desc_rows = rsp_desc_rows;
         w.desc_index = rsp_desc_index;
         w.run_last = rsp_run_last;
         w.pattern_done = rsp_pattern_done;
         sb.check_word(w);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("watchdog expired");
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic reg_write(csr_index_type idx, logic [31:0] val);
      @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      sb.write_reg(idx, val);
      @(posedge clock);
      csr_write <= 0;
   endtask

   task automatic drain();
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_pattern(logic [31:0] so, logic [23:0] rb, logic [23:0] rs,
                              logic [15:0] rt);
      drain();
      reg_write(CSR_START_OFFSET, so);
      reg_write(CSR_ROW_BYTES, rb);
      reg_write(CSR_ROW_STRIDE, rs);
      reg_write(CSR_ROW_TOTAL, rt);
   endtask

   // offer one word, hold it until accepted
   task automatic send_seg(logic [31:0] a, logic [24:0] s, bit f, bit l);
      req_valid <= 1;
      req_seg_addr <= a;
      req_seg_size <= s;
      req_first_segment <= f;
      req_last_segment <= l;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_segment(a, s, f, l);
      seg_count++;
   endtask

   task automatic rest();
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic random_run(int nseg);
      int burst;
      logic [24:0] s;
      burst = $urandom_range(1, 6);
      for (int i = 0; i < nseg; i++) begin
         case ($urandom_range(0, 9))
            0: s = $urandom_range(0, 25'h1FFFFFF) & 25'h1FFFFFF;
            1: s = 0;
            2: s = 25'h1000000;
            default: s = $urandom_range(1, 300);
         endcase
         if ($urandom_range(0, 19) == 0) s = $urandom_range(0, 25'h1FFFFFF);
         send_seg($urandom, s, (i == 0) ? 1 : ($urandom_range(0, 29) == 0),
                  (i == nseg - 1) ? 1 : ($urandom_range(0, 29) == 0));
         if (--burst == 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst = $urandom_range(1, 6);
         end
      end
      rest();
   endtask

   initial begin
      seg_count = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // closed run after reset: ignored
      send_seg(32'h1000, 25'd64, 0, 0);
      rest();
      set_pattern(32'd0, 24'd4, 24'd8, 16'd3);
      send_seg(32'hFFFF_FFF0, 25'd24, 1, 1);            // exact fit
      rest();
      set_pattern(32'd3, 24'd6, 24'd8, 16'd5);
      send_seg(32'h2000, 25'd12, 1, 0);                 // split row
      send_seg(32'h3000, 25'd2, 0, 0);                  // tail longer than segment
      send_seg(32'h4000, 25'd0, 0, 0);
      send_seg(32'h5000, 25'd40, 0, 1);
      send_seg(32'h6000, 25'd50, 0, 0);                 // closed
      send_seg(32'h7000, 25'd10, 1, 0);
      send_seg(32'h8000, 25'd13, 0, 1);                 // split on last segment
      rest();
      set_pattern(32'hFFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
      send_seg(32'h0, 25'h1FFFFFF, 1, 0);               // skipped
      send_seg(32'hFFFF_FFFF, 25'h1FFFFFF, 0, 1);
      rest();
      set_pattern(32'd0, 24'd1, 24'd0, 16'd0);          // zero stride, no rows
      send_seg(32'h10, 25'd5, 1, 1);
      rest();
      set_pattern(32'd10, 24'd1, 24'd0, 16'd4);
      send_seg(32'h10, 25'd5, 1, 0);
      send_seg(32'h20, 25'd20, 0, 0);
      rest();
      set_pattern(32'd2, 24'd20, 24'd8, 16'd4);         // overlong rows
      send_seg(32'h100, 25'd9, 1, 0);
      send_seg(32'h200, 25'h1000000, 0, 1);
      rest();
      // backpressure: hold the receiver while segments keep coming
      set_pattern(32'd1, 24'd3, 24'd5, 16'd40);
      hold_rsp = 1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         begin
            for (int i = 0; i < 12; i++) send_seg(32'h9000 + i * 64, 25'd17, i == 0, 0);
            rest();
         end
      join
      while (seg_count < 350) begin
         set_pattern($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64),
                     $urandom_range(0, 3) == 0 ? $urandom_range(1, 24'hFFFFFF)
                                              : $urandom_range(1, 40),
                     $urandom_range(0, 3) == 0 ? $urandom_range(1, 24'hFFFFFF)
                                              : $urandom_range(1, 48),
                     $urandom_range(0, 5) == 0 ? $urandom_range(0, 16'hFFFF)
                                              : $urandom_range(0, 30));
         random_run($urandom_range(2, 12));
      end
      drain();
      $display("covered %0d segments, %0d words checked, %0d short-buffer words",
               seg_count, sb.words_checked, sb.error_words);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire
